[rtl/macd_pkg.sv]
// Shared widths, register indexes, reset values, unit tags and types of the MACD block.
package macd_pkg;

    // Field widths.
    localparam int PRICE_W  = 32;
    localparam int AVG_W    = 48;
    localparam int WEIGHT_W = 17;
    localparam int COUNT_W  = 10;
    localparam int INDEX_W  = 2;

    // Weight of one in Q1.16.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    // Reset values of the configuration registers.
    localparam logic [WEIGHT_W-1:0] FAST_WEIGHT_RST   = 17'd10082;
    localparam logic [WEIGHT_W-1:0] SLOW_WEIGHT_RST   = 17'd4855;
    localparam logic [WEIGHT_W-1:0] SIGNAL_WEIGHT_RST = 17'd13107;
    localparam logic [COUNT_W-1:0]  WARMUP_COUNT_RST  = 10'd35;

    // Saturation point of the sample counter.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_FAST_WEIGHT   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SLOW_WEIGHT   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_SIGNAL_WEIGHT = 2'd2;
    localparam logic [INDEX_W-1:0] REG_WARMUP_COUNT  = 2'd3;

    // Tags that say which average an update in the shared unit belongs to.
    localparam logic [1:0] TAG_FAST   = 2'd0;
    localparam logic [1:0] TAG_SLOW   = 2'd1;
    localparam logic [1:0] TAG_SIGNAL = 2'd2;

    typedef struct packed {
        logic [WEIGHT_W-1:0] fast_weight;
        logic [WEIGHT_W-1:0] slow_weight;
        logic [WEIGHT_W-1:0] signal_weight;
        logic [COUNT_W-1:0]  warmup_count;
    } t_cfg;

    typedef struct packed {
        logic                    valid;
        logic [1:0]              tag;
        logic signed [AVG_W-1:0] avg;
        logic signed [AVG_W-1:0] target;
        logic [WEIGHT_W-1:0]     weight;
    } t_ema_req;

    typedef struct packed {
        logic                    valid;
        logic [1:0]              tag;
        logic signed [AVG_W-1:0] result;
    } t_ema_rsp;

endpackage

[rtl/macd_cfg_regs.sv]
// Configuration register file of the MACD block: weights and warm-up count.
module macd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [macd_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [macd_pkg::WEIGHT_W-1:0] i_cfg_data,
    output macd_pkg::t_cfg                o_cfg
);

    macd_pkg::t_cfg r_cfg;

    // A write lands in the register that its index selects.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_weight   <= macd_pkg::FAST_WEIGHT_RST;
            r_cfg.slow_weight   <= macd_pkg::SLOW_WEIGHT_RST;
            r_cfg.signal_weight <= macd_pkg::SIGNAL_WEIGHT_RST;
            r_cfg.warmup_count  <= macd_pkg::WARMUP_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                macd_pkg::REG_FAST_WEIGHT:   r_cfg.fast_weight   <= i_cfg_data;
                macd_pkg::REG_SLOW_WEIGHT:   r_cfg.slow_weight   <= i_cfg_data;
                macd_pkg::REG_SIGNAL_WEIGHT: r_cfg.signal_weight <= i_cfg_data;
                macd_pkg::REG_WARMUP_COUNT:
                    r_cfg.warmup_count <= i_cfg_data[macd_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/macd_ema_unit.sv]
// Shared three-stage EMA update unit: avg + round((target - avg) * w / 65536).
module macd_ema_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  macd_pkg::t_ema_req i_req,
    output macd_pkg::t_ema_rsp o_rsp
);

    localparam int DIFF_W = macd_pkg::AVG_W + 1;
    localparam int PROD_W = DIFF_W + macd_pkg::WEIGHT_W + 1;

    // Stage one: difference and clamped weight.
    logic                              r_s1_valid;
    logic [1:0]                        r_s1_tag;
    logic signed [macd_pkg::AVG_W-1:0] r_s1_avg;
    logic signed [DIFF_W-1:0]          r_s1_diff;
    logic [macd_pkg::WEIGHT_W-1:0]     r_s1_weight;

    // Stage two: product.
    logic                              r_s2_valid;
    logic [1:0]                        r_s2_tag;
    logic signed [macd_pkg::AVG_W-1:0] r_s2_avg;
    logic signed [PROD_W-1:0]          r_s2_prod;

    // Stage three: rounded result.
    logic                              r_s3_valid;
    logic [1:0]                        r_s3_tag;
    logic signed [macd_pkg::AVG_W-1:0] r_s3_result;

    logic signed [DIFF_W-1:0]          n_s1_diff;
    logic [macd_pkg::WEIGHT_W-1:0]     n_s1_weight;
    logic signed [PROD_W-1:0]          n_s2_prod;
    logic signed [PROD_W-1:0]          w_rounded;
    logic signed [PROD_W-1:0]          w_shifted;
    logic signed [macd_pkg::AVG_W-1:0] n_s3_result;

    // A weight above one acts as one.
    always_comb begin
        n_s1_diff   = {i_req.target[macd_pkg::AVG_W-1], i_req.target}
                    - {i_req.avg[macd_pkg::AVG_W-1], i_req.avg};
        n_s1_weight = (i_req.weight > macd_pkg::WEIGHT_ONE) ? macd_pkg::WEIGHT_ONE
                                                            : i_req.weight;
    end

    // The weight is unsigned, so it goes into the product with a zero sign bit.
    assign n_s2_prod = PROD_W'(r_s1_diff * $signed({1'b0, r_s1_weight}));

    // Round half up, then floor by an arithmetic shift.
    always_comb begin
        w_rounded   = r_s2_prod + PROD_W'(32768);
        w_shifted   = w_rounded >>> 16;
        n_s3_result = r_s2_avg + w_shifted[macd_pkg::AVG_W-1:0];
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        r_s1_tag    <= i_req.tag;
        r_s1_avg    <= i_req.avg;
        r_s1_diff   <= n_s1_diff;
        r_s1_weight <= n_s1_weight;
        r_s2_tag    <= r_s1_tag;
        r_s2_avg    <= r_s1_avg;
        r_s2_prod   <= n_s2_prod;
        r_s3_tag    <= r_s2_tag;
        r_s3_result <= n_s3_result;
    end

    assign o_rsp.valid  = r_s3_valid;
    assign o_rsp.tag    = r_s3_tag;
    assign o_rsp.result = r_s3_result;

endmodule

[rtl/macd_indicator_stream_unit.sv]
// Top level of the MACD indicator stream: sequencer, averages and output register.
//
//  Channel   Direction  Handshake                       Word contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata: close_price; tuser: restart
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: dif, dea, hist; tuser: ready_res
//  cfg       in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// A seeding word goes straight to the output step. For an ordinary word the
// fast and slow updates go back to back through the
// shared three-stage multiply unit, and the signal update waits for both.
// Reset is synchronous and active low; the next word after reset seeds.
// A result waits in the output register while the master side stalls; the
// sequencer holds its last step until that register is free.
module macd_indicator_stream_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,  // [31:0] close_price
    input  logic                          i_s_axis_tuser,  // [0] restart
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [143:0]                  o_m_axis_tdata,  // [47:0] dif, [95:48] dea,
                                                           // [143:96] hist
    output logic                          o_m_axis_tuser,  // [0] ready_res
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [macd_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [macd_pkg::WEIGHT_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FAST  = 3'd1;
    localparam logic [2:0] S_SLOW  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_SIG   = 3'd4;
    localparam logic [2:0] S_SWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    macd_pkg::t_cfg     w_cfg;
    macd_pkg::t_ema_req w_req;
    macd_pkg::t_ema_rsp w_rsp;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic                              r_seeded;
    logic [macd_pkg::COUNT_W-1:0]      r_count;
    logic [macd_pkg::COUNT_W-1:0]      n_count;
    logic signed [macd_pkg::AVG_W-1:0] r_price;
    logic signed [macd_pkg::AVG_W-1:0] r_fast;
    logic signed [macd_pkg::AVG_W-1:0] r_slow;
    logic signed [macd_pkg::AVG_W-1:0] r_sig;
    logic                              r_out_valid;
    logic [143:0]                      r_out_data;
    logic                              r_out_ready_res;

    logic                              w_in_accept;
    logic                              w_seed;
    logic                              w_out_load;
    logic signed [macd_pkg::AVG_W-1:0] w_dif;
    logic signed [macd_pkg::AVG_W-1:0] w_hist;
    logic signed [macd_pkg::AVG_W-1:0] w_price_q24;

    macd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    macd_ema_unit u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Handshakes.
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_seed          = i_s_axis_tuser || !r_seeded;
    assign w_out_load      = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // Price widened from Q16.16 to Q24.24.
    assign w_price_q24 = {8'd0, i_s_axis_tdata, 8'd0};

    // Differences taken from the stored averages.
    assign w_dif  = r_fast - r_slow;
    assign w_hist = w_dif - r_sig;

    // Requests to the shared unit, one per issue step.
    always_comb begin
        w_req.valid  = 1'b0;
        w_req.tag    = macd_pkg::TAG_FAST;
        w_req.avg    = r_fast;
        w_req.target = r_price;
        w_req.weight = w_cfg.fast_weight;
        case (r_state)
            S_FAST: begin
                w_req.valid = 1'b1;
            end
            S_SLOW: begin
                w_req.valid  = 1'b1;
                w_req.tag    = macd_pkg::TAG_SLOW;
                w_req.avg    = r_slow;
                w_req.weight = w_cfg.slow_weight;
            end
            S_SIG: begin
                w_req.valid  = 1'b1;
                w_req.tag    = macd_pkg::TAG_SIGNAL;
                w_req.avg    = r_sig;
                w_req.target = w_dif;
                w_req.weight = w_cfg.signal_weight;
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_accept) n_state = w_seed ? S_OUT : S_FAST;
            S_FAST:  n_state = S_SLOW;
            S_SLOW:  n_state = S_WAIT;
            S_WAIT:  if (w_rsp.valid && (w_rsp.tag == macd_pkg::TAG_SLOW)) n_state = S_SIG;
            S_SIG:   n_state = S_SWAIT;
            S_SWAIT: if (w_rsp.valid && (w_rsp.tag == macd_pkg::TAG_SIGNAL)) n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sample count: one on a seed, otherwise up to saturation.
    always_comb begin
        n_count = r_count;
        if (w_in_accept) begin
            if (w_seed) begin
                n_count = macd_pkg::COUNT_W'(1);
            end else if (r_count < macd_pkg::COUNT_MAX) begin
                n_count = r_count + macd_pkg::COUNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_in_accept) begin
                r_seeded <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Averages: seeded on acceptance, updated as the shared unit returns.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_price <= w_price_q24;
            if (w_seed) begin
                r_fast <= w_price_q24;
                r_slow <= w_price_q24;
                r_sig  <= '0;
            end
        end
        if (w_rsp.valid) begin
            case (w_rsp.tag)
                macd_pkg::TAG_FAST:   r_fast <= w_rsp.result;
                macd_pkg::TAG_SLOW:   r_slow <= w_rsp.result;
                macd_pkg::TAG_SIGNAL: r_sig  <= w_rsp.result;
                default: begin
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data      <= {w_hist, r_sig, w_dif};
            r_out_ready_res <= (r_count >= w_cfg.warmup_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_ready_res;

endmodule

[rtl/macd_stream_checker.sv]
// Port-level checker of the MACD indicator stream, bound to the top level.
module macd_stream_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [143:0] o_m_axis_tdata
);

    // A stalled result word holds its valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // One word is worked at a time: the slave side closes after acceptance.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a word is in progress");

    // When a new result appears the block is free for the next word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("sequencer not idle after producing a result");

    // A restart word with a free output gives an all-zero result from the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser && !o_m_axis_tvalid)
        |-> ##2 (o_m_axis_tvalid && (o_m_axis_tdata == 144'd0)))
        else $error("seeding word did not give a zero result");

endmodule

bind macd_indicator_stream_unit macd_stream_checker u_macd_chk (.*);

[tb/sv/macd_check_pkg.sv]
// Scoreboard class that predicts and checks the MACD result words.
`timescale 1ns / 1ps

package macd_check_pkg;

    // One result word as it leaves the master side.
    typedef struct packed {
        logic signed [macd_pkg::AVG_W-1:0] dif;
        logic signed [macd_pkg::AVG_W-1:0] dea;
        logic signed [macd_pkg::AVG_W-1:0] hist;
        logic                              ready;
    } t_macd_bar;

    class macd_bar_checker;

        // Mirror of the configuration registers.
        logic [macd_pkg::WEIGHT_W-1:0]     fast_w;
        logic [macd_pkg::WEIGHT_W-1:0]     slow_w;
        logic [macd_pkg::WEIGHT_W-1:0]     signal_w;
        logic [macd_pkg::COUNT_W-1:0]      warmup;

        // Mirror of the averages and the series state.
        logic signed [macd_pkg::AVG_W-1:0] fast_avg;
        logic signed [macd_pkg::AVG_W-1:0] slow_avg;
        logic signed [macd_pkg::AVG_W-1:0] signal_avg;
        logic [macd_pkg::COUNT_W-1:0]      samples;
        bit                                seeded;

        t_macd_bar                         pending_bars[$];
        int unsigned                       fails;
        int unsigned                       bars_checked;
        int unsigned                       seeds;
        int unsigned                       ready_bars;

        function new();
            fast_w     = macd_pkg::FAST_WEIGHT_RST;
            slow_w     = macd_pkg::SLOW_WEIGHT_RST;
            signal_w   = macd_pkg::SIGNAL_WEIGHT_RST;
            warmup     = macd_pkg::WARMUP_COUNT_RST;
            fast_avg   = '0;
            slow_avg   = '0;
            signal_avg = '0;
            samples    = '0;
            seeded     = 1'b0;
        endfunction

        function void write_register(logic [macd_pkg::INDEX_W-1:0] idx,
                                     logic [macd_pkg::WEIGHT_W-1:0] data);
            case (idx)
                macd_pkg::REG_FAST_WEIGHT: begin
                    fast_w = data;
                end
                macd_pkg::REG_SLOW_WEIGHT: begin
                    slow_w = data;
                end
                macd_pkg::REG_SIGNAL_WEIGHT: begin
                    signal_w = data;
                end
                macd_pkg::REG_WARMUP_COUNT: begin
                    warmup = data[macd_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // One EMA update: the rounding adds one half and then floors, and a
        // weight above one is treated as exactly one.
        function logic signed [macd_pkg::AVG_W-1:0] ema_step(
                logic signed [macd_pkg::AVG_W-1:0] avg,
                logic signed [macd_pkg::AVG_W-1:0] target,
                logic [macd_pkg::WEIGHT_W-1:0]     w);
            longint eff;
            longint prod;
            eff  = (w > macd_pkg::WEIGHT_ONE) ? longint'(macd_pkg::WEIGHT_ONE) : longint'(w);
            prod = (longint'(target) - longint'(avg)) * eff;
            return avg + macd_pkg::AVG_W'((prod + 64'sd32768) >>> 16);
        endfunction

        // Works out the result word of an accepted close price.
        function void note_close(logic [macd_pkg::PRICE_W-1:0] price, logic restart);
            logic signed [macd_pkg::AVG_W-1:0] target;
            t_macd_bar                         bar;
            target = {8'd0, price, 8'd0};
            if (restart || !seeded) begin
                fast_avg   = target;
                slow_avg   = target;
                signal_avg = '0;
                samples    = macd_pkg::COUNT_W'(1);
                seeded     = 1'b1;
                seeds++;
            end else begin
                fast_avg   = ema_step(fast_avg, target, fast_w);
                slow_avg   = ema_step(slow_avg, target, slow_w);
                signal_avg = ema_step(signal_avg, fast_avg - slow_avg, signal_w);
                if (samples != macd_pkg::COUNT_MAX) begin
                    samples++;
                end
            end
            bar.dif   = fast_avg - slow_avg;
            bar.dea   = signal_avg;
            bar.hist  = bar.dif - signal_avg;
            bar.ready = (samples >= warmup);
            pending_bars.push_back(bar);
        endfunction

        // Compares a result word with the oldest prediction.
        function void check_bar(t_macd_bar got);
            t_macd_bar want;
            if (pending_bars.size() == 0) begin
                $error("Result word arrived with no close price outstanding");
                fails++;
                return;
            end
            want = pending_bars.pop_front();
            bars_checked++;
            if (want.ready) begin
                ready_bars++;
            end
            if (got.dif !== want.dif) begin
                $error("dif_value: expected %0d, got %0d", want.dif, got.dif);
                fails++;
            end
            if (got.dea !== want.dea) begin
                $error("dea_value: expected %0d, got %0d", want.dea, got.dea);
                fails++;
            end
            if (got.hist !== want.hist) begin
                $error("hist_value: expected %0d, got %0d", want.hist, got.hist);
                fails++;
            end
            if (got.ready !== want.ready) begin
                $error("ready_res: expected %0d, got %0d", want.ready, got.ready);
                fails++;
            end
        endfunction

        function int pending();
            return pending_bars.size();
        endfunction

    endclass

endpackage

[tb/sv/testbench.sv]
// Top-level testbench of the MACD indicator stream unit.
`timescale 1ns / 1ps

module testbench;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [31:0]                   i_s_axis_tdata  = '0;
    logic                          i_s_axis_tuser  = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [143:0]                  o_m_axis_tdata;
    logic                          o_m_axis_tuser;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [macd_pkg::INDEX_W-1:0]  i_cfg_index     = '0;
    logic [macd_pkg::WEIGHT_W-1:0] i_cfg_data      = '0;

    macd_check_pkg::macd_bar_checker bars = new();

    // Idling controls shared by the drivers.
    bit          tx_gaps   = 1'b0;
    bit          rx_stalls = 1'b0;
    int          rx_hold   = 0;
    int          rx_wait   = 0;
    int unsigned settings  = 0;
    int unsigned closes    = 0;

    macd_indicator_stream_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Length of one idle stretch: mostly short, now and then long.
    function automatic int idle_span();
        if ($urandom_range(0, 99) < 75) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Weight choice that favours the extremes and otherwise uses a period.
    function automatic logic [macd_pkg::WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return macd_pkg::WEIGHT_ONE;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'd1;
            default: return 17'(131072 / ($urandom_range(2, 200) + 1));
        endcase
    endfunction

    // Warmup written with random bits above the ten that count.
    function automatic logic [macd_pkg::WEIGHT_W-1:0] pick_warmup();
        logic [macd_pkg::COUNT_W-1:0] span;
        case ($urandom_range(0, 7))
            0: span = '0;
            1: span = macd_pkg::COUNT_MAX;
            default: span = 10'($urandom_range(1, 80));
        endcase
        return {7'($urandom), span};
    endfunction

    // Receiver: a long hold requested by the stimulus wins, otherwise random
    // stalls while they are enabled.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_wait > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
            i_m_axis_tready <= 1'b0;
            rx_wait = idle_span() - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge i_clk) begin
        macd_check_pkg::t_macd_bar word_out;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            word_out.dif   = o_m_axis_tdata[47:0];
            word_out.dea   = o_m_axis_tdata[95:48];
            word_out.hist  = o_m_axis_tdata[143:96];
            word_out.ready = o_m_axis_tuser;
            bars.check_bar(word_out);
        end
    end

    // Drops the input valid for an idle stretch whose length n gives.
    task automatic pause_sender(input int n);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offers one close price and waits until the block takes it.
    task automatic send_close(input logic [31:0] price, input logic restart);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= price;
        i_s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bars.note_close(price, restart);
        closes++;
        if (tx_gaps && $urandom_range(0, 99) < 35) begin
            pause_sender(idle_span());
        end
    endtask

    // Stops the sender and waits until every result word is back.
    task automatic drain_block();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (bars.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [macd_pkg::INDEX_W-1:0] idx,
                                  input logic [macd_pkg::WEIGHT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        bars.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads a full set of registers once the block has gone quiet.
    task automatic configure(input logic [macd_pkg::WEIGHT_W-1:0] fast,
                             input logic [macd_pkg::WEIGHT_W-1:0] slow,
                             input logic [macd_pkg::WEIGHT_W-1:0] sig,
                             input logic [macd_pkg::WEIGHT_W-1:0] warm);
        drain_block();
        write_register(macd_pkg::REG_FAST_WEIGHT, fast);
        write_register(macd_pkg::REG_SLOW_WEIGHT, slow);
        write_register(macd_pkg::REG_SIGNAL_WEIGHT, sig);
        write_register(macd_pkg::REG_WARMUP_COUNT, warm);
        settings++;
    endtask

    // Mostly price series that walk from a random start, with some noise
    // words carrying arbitrary prices and restart flags.
    task automatic random_series(input int count);
        int          left;
        int          walk;
        logic [31:0] price;
        logic        restart;
        left  = 0;
        price = '0;
        for (int k = 0; k < count; k++) begin
            walk = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            if ($urandom_range(0, 9) == 0) begin
                price   = $urandom;
                restart = 1'($urandom_range(0, 1));
            end else if (left == 0) begin
                price   = $urandom;
                restart = 1'b1;
                left    = $urandom_range(10, 90);
            end else begin
                price   = price + walk;
                restart = 1'b0;
                left--;
            end
            send_close(price, restart);
        end
    endtask

    initial begin
        int          walk;
        logic [31:0] price;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: the first word seeds without a restart flag,
        // then full-scale jumps, bit patterns and restarts in mid series.
        send_close(32'h0000_0000, 1'b0);
        send_close(32'hFFFF_FFFF, 1'b0);
        send_close(32'hFFFF_FFFF, 1'b0);
        send_close(32'h0000_0000, 1'b0);
        send_close(32'h8000_0000, 1'b1);
        send_close(32'h7FFF_FFFF, 1'b0);
        send_close(32'h0001_0000, 1'b0);
        send_close(32'hFFFF_0000, 1'b0);
        send_close(32'h0000_FFFF, 1'b0);
        send_close(32'h5555_5555, 1'b0);
        send_close(32'hAAAA_AAAA, 1'b0);
        send_close(32'h0000_0000, 1'b1);
        send_close(32'h0000_0001, 1'b0);

        // Weight of one, zero weight, weight above one and zero warmup.
        configure(macd_pkg::WEIGHT_ONE, '0, 17'h1FFFF, '0);
        send_close(32'h1234_5678, 1'b1);
        send_close(32'hFFFF_FFFF, 1'b0);
        send_close(32'h0000_0000, 1'b0);
        send_close(32'hDEAD_BEEF, 1'b0);
        configure('0, macd_pkg::WEIGHT_ONE, 17'd65537, 17'd1);
        send_close(32'hFFFF_FFFF, 1'b0);
        send_close(32'h0000_0000, 1'b0);
        send_close(32'h89AB_CDEF, 1'b1);
        send_close(32'h0000_0000, 1'b0);

        // Receiver holds off while the sender keeps offering words, then the
        // sender waits for every result.
        configure(pick_weight(), pick_weight(), pick_weight(), pick_warmup());
        rx_hold = 300;
        random_series(14);
        drain_block();

        // One long series: the ready flag rises part way through and stays up.
        configure(pick_weight(), pick_weight(), pick_weight(), {7'h55, 10'd200});
        price = $urandom;
        send_close(price, 1'b1);
        for (int k = 0; k < 300; k++) begin
            walk  = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            price = price + walk;
            send_close(price, 1'b0);
        end

        // Random register values with idling switched per phase.
        for (int phase = 0; phase < 8; phase++) begin
            configure(pick_weight(), pick_weight(), pick_weight(), pick_warmup());
            tx_gaps   = (phase % 4) != 1;
            rx_stalls = (phase % 3) != 2;
            random_series(63);
            if (phase == 3) begin
                drain_block();
            end
        end

        drain_block();
        $display("Run covered %0d close prices with %0d seeded series under %0d configurations.",
                 closes, bars.seeds, settings + 1);
        $display("Checked %0d result words, %0d of them ready, with %0d mismatches.",
                 bars.bars_checked, bars.ready_bars, bars.fails);
        if (bars.fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
